// ===== rtl/three_tone_goertzel_detector_unit_macros.svh =====
// assertion macros for the three-tone goertzel detector
// used by the sequencer, expects clk_i and rst_ni in scope
`ifndef THREE_TONE_GOERTZEL_DETECTOR_UNIT_MACROS_SVH
`define THREE_TONE_GOERTZEL_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication
`define TTGD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// delayed implication
`define TTGD_ASSERT_AFTER5(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##5 (cons)) \
    else $error(msg);

`endif

// ===== rtl/ttgd_pkg.sv =====
// shared types and constants of the three-tone goertzel detector
// no dependencies
`timescale 1ns / 1ps

package ttgd_pkg;

  localparam int unsigned CoefW     = 16;
  localparam int unsigned DigW      = 16;
  localparam int unsigned FracW     = 14;
  localparam int unsigned MagW      = 63;
  localparam int unsigned WideW     = 64;
  localparam int unsigned RatioDigs = 4;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned ResW      = 3 * MagW + 3;

  localparam logic [MagW-1:0]  MagMax     = '1;
  localparam logic [CoefW-1:0] RatioReset = 16'd512;

  typedef enum logic [1:0] {
    REG_COEF_A    = 2'd0,
    REG_COEF_B    = 2'd1,
    REG_COEF_C    = 2'd2,
    REG_MIN_RATIO = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    MAC_NOP,
    MAC_MUL,
    MAC_ADD,
    MAC_SUB,
    MAC_NSH,
    MAC_LDS
  } mac_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMP,
    ST_MCS,
    ST_MCL,
    ST_MT,
    ST_MNS,
    ST_MS1,
    ST_MS2,
    ST_MCP,
    ST_DB1,
    ST_DB2,
    ST_DLD,
    ST_DRT,
    ST_OUT
  } seq_state_e;

  typedef struct packed {
    mac_op_e                op;
    logic [1:0]             pos;
    logic signed [DigW:0]   dig;
  } mac_ctl_t;

  typedef struct packed {
    logic [2:0][CoefW-1:0] coef;
    logic [CoefW-1:0]      min_ratio;
  } cfg_t;

  typedef struct packed {
    logic [1:0]      bin;
    logic            found;
    logic [MagW-1:0] mag_c;
    logic [MagW-1:0] mag_b;
    logic [MagW-1:0] mag_a;
  } res_t;

  // 16-bit digit k of v, sign taken from the digit only for the top digit
  function automatic logic signed [DigW:0] digit_of(logic [WideW-1:0] v, logic [1:0] k,
                                                     logic top);
    logic [DigW-1:0] c;
    c = v[{k, 4'b0000} +: DigW];
    return {top & c[DigW-1], c};
  endfunction

endpackage

// ===== rtl/ttgd_cfg.sv =====
// apb register file: three bin coefficients and the dominance ratio
// depends on ttgd_pkg
`timescale 1ns / 1ps

module ttgd_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [ttgd_pkg::AddrW-1:0]  paddr_i,
  input  logic [31:0]                 pwdata_i,
  output logic [31:0]                 prdata_o,
  output ttgd_pkg::cfg_t              cfg_o
);

  ttgd_pkg::cfg_t     cfg_q, cfg_d;
  ttgd_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx   = ttgd_pkg::reg_idx_e'(paddr_i[3:2]);
  assign wr_en = psel_i && penable_i && pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        ttgd_pkg::REG_COEF_A:    cfg_d.coef[0]   = pwdata_i[15:0];
        ttgd_pkg::REG_COEF_B:    cfg_d.coef[1]   = pwdata_i[15:0];
        ttgd_pkg::REG_COEF_C:    cfg_d.coef[2]   = pwdata_i[15:0];
        ttgd_pkg::REG_MIN_RATIO: cfg_d.min_ratio = pwdata_i[15:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ttgd_pkg::REG_COEF_A:    prdata_o = 32'(cfg_q.coef[0]);
      ttgd_pkg::REG_COEF_B:    prdata_o = 32'(cfg_q.coef[1]);
      ttgd_pkg::REG_COEF_C:    prdata_o = 32'(cfg_q.coef[2]);
      ttgd_pkg::REG_MIN_RATIO: prdata_o = 32'(cfg_q.min_ratio);
      default:                 prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef      <= '0;
      cfg_q.min_ratio <= ttgd_pkg::RatioReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/ttgd_mac.sv =====
// shared multiply-accumulate unit: full operand times one 17-bit digit, shifted by
// whole digits into a wide accumulator, plus negate-shift and load ops; depends on ttgd_pkg
`timescale 1ns / 1ps

module ttgd_mac #(
  parameter int unsigned AW   = 56,
  parameter int unsigned ACCW = 96
) (
  input  logic                          clk_i,
  input  ttgd_pkg::mac_ctl_t            ctl_i,
  input  logic signed [AW-1:0]          a_i,
  input  logic [ttgd_pkg::MagW-1:0]     top_i,
  output logic signed [ACCW-1:0]        acc_o
);

  localparam int unsigned PW = AW + ttgd_pkg::DigW + 1;

  logic signed [PW-1:0]   prod;
  logic signed [ACCW-1:0] prod_ext;
  logic signed [ACCW-1:0] prod_sh;
  logic signed [ACCW-1:0] acc_asr;
  logic signed [ACCW-1:0] acc_q, acc_d;

  assign prod     = $signed(a_i) * $signed(ctl_i.dig);
  assign prod_ext = ACCW'(prod);
  assign prod_sh  = prod_ext <<< {ctl_i.pos, 4'b0000};
  assign acc_asr  = acc_q >>> ttgd_pkg::FracW;

  always_comb begin
    unique case (ctl_i.op)
      ttgd_pkg::MAC_NOP: acc_d = acc_q;
      ttgd_pkg::MAC_MUL: acc_d = prod_sh;
      ttgd_pkg::MAC_ADD: acc_d = acc_q + prod_sh;
      ttgd_pkg::MAC_SUB: acc_d = acc_q - prod_sh;
      ttgd_pkg::MAC_NSH: acc_d = -acc_asr;
      ttgd_pkg::MAC_LDS: acc_d = ACCW'({top_i, 8'h00});
      default:           acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/ttgd_seq.sv =====
// sequencer: bin delay lines, per-sample recurrence, magnitudes and dominance
// test, all through the shared mac; depends on ttgd_pkg and the macro header
`timescale 1ns / 1ps
`include "three_tone_goertzel_detector_unit_macros.svh"

module ttgd_seq #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned STATE_BITS  = 40
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]                 in_sample_i,
  input  logic                                          in_last_i,
  input  ttgd_pkg::cfg_t                                cfg_i,
  output ttgd_pkg::mac_ctl_t                            mac_ctl_o,
  output logic signed [STATE_BITS+ttgd_pkg::CoefW-1:0]  mac_a_o,
  output logic [ttgd_pkg::MagW-1:0]                     mac_top_o,
  input  logic signed [2*STATE_BITS+ttgd_pkg::CoefW-1:0] mac_acc_i,
  output logic                                          res_valid_o,
  input  logic                                          res_ready_i,
  output ttgd_pkg::res_t                                res_o
);

  localparam int unsigned SB      = STATE_BITS;
  localparam int unsigned AW      = SB + ttgd_pkg::CoefW;
  localparam int unsigned ACCW    = 2 * SB + ttgd_pkg::CoefW;
  localparam int unsigned SW      = SB + 3;
  localparam int unsigned NDig    = (SB + ttgd_pkg::DigW - 1) / ttgd_pkg::DigW;
  localparam logic [1:0]  LastDig = 2'(NDig - 1);
  localparam logic [1:0]  LastRat = 2'(ttgd_pkg::RatioDigs - 1);
  localparam logic [1:0]  LastBin = 2'd2;
  localparam logic [1:0]  LastStp = 2'd3;
  localparam int unsigned MagW    = ttgd_pkg::MagW;

  ttgd_pkg::seq_state_e   state_q, state_d;
  logic [1:0]             cnt_q, cnt_d;
  logic [1:0]             bin_q, bin_d;
  logic [1:0]             best_q, best_d;
  logic signed [SAMPLE_BITS-1:0] x_q, x_d;
  logic                   last_q, last_d;
  logic [2:0][SB-1:0]     s1_q, s1_d;
  logic [2:0][SB-1:0]     s2_q, s2_d;
  logic [AW-1:0]          cs1_q, cs1_d;
  logic [MagW-1:0]        mag_a_q, mag_a_d, mag_b_q, mag_b_d, mag_c_q, mag_c_d;
  logic [MagW-1:0]        top_q, top_d, low_q, low_d, sec_q, sec_d;

  logic                   in_fire;
  logic [1:0]             coef_idx;
  logic [ttgd_pkg::CoefW-1:0] coef_sel;
  logic signed [SB+1:0]   prod_p;
  logic signed [SW-1:0]   upd_sum;
  logic [SB-1:0]          s0;
  logic [MagW-1:0]        mag_clamp;
  logic                   found;
  logic                   dig_top;

  assign in_ready_o = (state_q == ttgd_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign mac_top_o  = top_q;
  assign dig_top    = (cnt_q == LastDig);

  assign coef_idx = (state_q == ttgd_pkg::ST_SMP) ? cnt_q : bin_q;
  always_comb begin
    unique case (coef_idx)
      2'd0:    coef_sel = cfg_i.coef[0];
      2'd1:    coef_sel = cfg_i.coef[1];
      default: coef_sel = cfg_i.coef[2];
    endcase
  end

  // recurrence for the bin sitting in slot 2, product from the previous slot
  assign prod_p  = $signed(mac_acc_i[SB+ttgd_pkg::CoefW-1:ttgd_pkg::FracW]);
  assign upd_sum = SW'(x_q) + SW'(prod_p) - SW'($signed(s2_q[2]));
  always_comb begin
    if ((upd_sum[SW-1:SB-1] == '0) || (upd_sum[SW-1:SB-1] == '1)) begin
      s0 = upd_sum[SB-1:0];
    end else if (upd_sum[SW-1]) begin
      s0 = {1'b1, {(SB-1){1'b0}}};
    end else begin
      s0 = {1'b0, {(SB-1){1'b1}}};
    end
  end

  always_comb begin
    if (mac_acc_i[ACCW-1]) begin
      mag_clamp = '0;
    end else if (|mac_acc_i[ACCW-2:MagW]) begin
      mag_clamp = ttgd_pkg::MagMax;
    end else begin
      mag_clamp = mac_acc_i[MagW-1:0];
    end
  end

  assign found = (top_q != '0) && !mac_acc_i[ACCW-1];

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    bin_d     = bin_q;
    best_d    = best_q;
    x_d       = x_q;
    last_d    = last_q;
    s1_d      = s1_q;
    s2_d      = s2_q;
    cs1_d     = cs1_q;
    mag_a_d   = mag_a_q;
    mag_b_d   = mag_b_q;
    mag_c_d   = mag_c_q;
    top_d     = top_q;
    low_d     = low_q;
    sec_d     = sec_q;
    mac_ctl_o = '{op: ttgd_pkg::MAC_NOP, pos: 2'd0, dig: '0};
    mac_a_o   = '0;
    res_valid_o = 1'b0;
    res_o     = '0;

    unique case (state_q)
      ttgd_pkg::ST_IDLE: begin
        if (in_fire) begin
          x_d     = in_sample_i;
          last_d  = in_last_i;
          cnt_d   = 2'd0;
          state_d = ttgd_pkg::ST_SMP;
        end
      end
      ttgd_pkg::ST_SMP: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q != LastStp) begin
          mac_ctl_o = '{op: ttgd_pkg::MAC_MUL, pos: 2'd0,
                        dig: ttgd_pkg::DigW'(0) + $signed(coef_sel)};
          mac_a_o   = AW'($signed(s1_q[0]));
          s1_d = {s1_q[0], s1_q[2], s1_q[1]};
          s2_d = {s2_q[0], s2_q[2], s2_q[1]};
          if (cnt_q != 2'd0) begin
            s1_d[1] = s0;
            s2_d[1] = s1_q[2];
          end
        end else begin
          s1_d[2] = s0;
          s2_d[2] = s1_q[2];
          bin_d   = 2'd0;
          state_d = last_q ? ttgd_pkg::ST_MCS : ttgd_pkg::ST_IDLE;
        end
      end
      ttgd_pkg::ST_MCS: begin
        mac_ctl_o = '{op: ttgd_pkg::MAC_MUL, pos: 2'd0,
                      dig: ttgd_pkg::DigW'(0) + $signed(coef_sel)};
        mac_a_o   = AW'($signed(s1_q[0]));
        state_d   = ttgd_pkg::ST_MCL;
      end
      ttgd_pkg::ST_MCL: begin
        cs1_d   = mac_acc_i[AW-1:0];
        cnt_d   = 2'd0;
        state_d = ttgd_pkg::ST_MT;
      end
      ttgd_pkg::ST_MT: begin
        mac_ctl_o.op  = (cnt_q == 2'd0) ? ttgd_pkg::MAC_MUL : ttgd_pkg::MAC_ADD;
        mac_ctl_o.pos = cnt_q;
        mac_ctl_o.dig = ttgd_pkg::digit_of(ttgd_pkg::WideW'($signed(s2_q[0])), cnt_q,
                                            dig_top);
        mac_a_o       = $signed(cs1_q);
        cnt_d         = cnt_q + 2'd1;
        if (dig_top) begin
          cnt_d   = 2'd0;
          state_d = ttgd_pkg::ST_MNS;
        end
      end
      ttgd_pkg::ST_MNS: begin
        mac_ctl_o.op = ttgd_pkg::MAC_NSH;
        state_d      = ttgd_pkg::ST_MS1;
      end
      ttgd_pkg::ST_MS1, ttgd_pkg::ST_MS2: begin
        mac_ctl_o.op  = ttgd_pkg::MAC_ADD;
        mac_ctl_o.pos = cnt_q;
        if (state_q == ttgd_pkg::ST_MS1) begin
          mac_ctl_o.dig = ttgd_pkg::digit_of(ttgd_pkg::WideW'($signed(s1_q[0])), cnt_q,
                                              dig_top);
          mac_a_o       = AW'($signed(s1_q[0]));
        end else begin
          mac_ctl_o.dig = ttgd_pkg::digit_of(ttgd_pkg::WideW'($signed(s2_q[0])), cnt_q,
                                              dig_top);
          mac_a_o       = AW'($signed(s2_q[0]));
        end
        cnt_d = cnt_q + 2'd1;
        if (dig_top) begin
          cnt_d   = 2'd0;
          state_d = (state_q == ttgd_pkg::ST_MS1) ? ttgd_pkg::ST_MS2 : ttgd_pkg::ST_MCP;
        end
      end
      ttgd_pkg::ST_MCP: begin
        mag_c_d = mag_clamp;
        mag_b_d = mag_c_q;
        mag_a_d = mag_b_q;
        s1_d    = {{SB{1'b0}}, s1_q[2], s1_q[1]};
        s2_d    = {{SB{1'b0}}, s2_q[2], s2_q[1]};
        bin_d   = bin_q + 2'd1;
        state_d = (bin_q == LastBin) ? ttgd_pkg::ST_DB1 : ttgd_pkg::ST_MCS;
      end
      ttgd_pkg::ST_DB1: begin
        if (mag_b_q > mag_a_q) begin
          best_d = 2'd1;
          top_d  = mag_b_q;
          low_d  = mag_a_q;
        end else begin
          best_d = 2'd0;
          top_d  = mag_a_q;
          low_d  = mag_b_q;
        end
        state_d = ttgd_pkg::ST_DB2;
      end
      ttgd_pkg::ST_DB2: begin
        if (mag_c_q > top_q) begin
          best_d = 2'd2;
          top_d  = mag_c_q;
          sec_d  = top_q;
        end else begin
          sec_d  = (mag_c_q > low_q) ? mag_c_q : low_q;
        end
        state_d = ttgd_pkg::ST_DLD;
      end
      ttgd_pkg::ST_DLD: begin
        mac_ctl_o.op = ttgd_pkg::MAC_LDS;
        cnt_d        = 2'd0;
        state_d      = ttgd_pkg::ST_DRT;
      end
      ttgd_pkg::ST_DRT: begin
        mac_ctl_o.op  = ttgd_pkg::MAC_SUB;
        mac_ctl_o.pos = cnt_q;
        mac_ctl_o.dig = ttgd_pkg::digit_of(ttgd_pkg::WideW'(sec_q), cnt_q, 1'b0);
        mac_a_o       = AW'(cfg_i.min_ratio);
        cnt_d         = cnt_q + 2'd1;
        if (cnt_q == LastRat) begin
          cnt_d   = 2'd0;
          state_d = ttgd_pkg::ST_OUT;
        end
      end
      ttgd_pkg::ST_OUT: begin
        res_valid_o = 1'b1;
        res_o.mag_a = mag_a_q;
        res_o.mag_b = mag_b_q;
        res_o.mag_c = mag_c_q;
        res_o.found = found;
        res_o.bin   = found ? best_q : 2'd0;
        if (res_ready_i) begin
          state_d = ttgd_pkg::ST_IDLE;
        end
      end
      default: state_d = ttgd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttgd_pkg::ST_IDLE;
      cnt_q   <= '0;
      bin_q   <= '0;
      s1_q    <= '0;
      s2_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bin_q   <= bin_d;
      s1_q    <= s1_d;
      s2_q    <= s2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q  <= best_d;
    x_q     <= x_d;
    last_q  <= last_d;
    cs1_q   <= cs1_d;
    mag_a_q <= mag_a_d;
    mag_b_q <= mag_b_d;
    mag_c_q <= mag_c_d;
    top_q   <= top_d;
    low_q   <= low_d;
    sec_q   <= sec_d;
  end

  `TTGD_ASSERT_IMP(a_delay_cleared, state_q == ttgd_pkg::ST_DB1, (s1_q == '0) && (s2_q == '0), "delay lines not cleared after block")
  `TTGD_ASSERT_AFTER5(a_plain_sample_done, in_fire && !in_last_i, state_q == ttgd_pkg::ST_IDLE, "unmarked word did not finish in four slots")
  `TTGD_ASSERT_IMP(a_result_bin, res_valid_o, (res_o.bin != 2'd3) && (res_o.found || (res_o.bin == 2'd0)), "bad dominant bin in result")

endmodule

// ===== rtl/three_tone_goertzel_detector_unit.sv =====
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata: sample; tlast: last_sample
// m_axis    out  m_axis_tvalid/tready       tdata: mag a, b, c, found, bin
// apb       in   psel/penable/pwrite        coeff a, b, c, min_ratio at 0x0..0xc
//
// unmarked word: accepted in idle, then each bin updated through the shared multiplier
// marked word: the update, then per-bin magnitudes and the ratio test digit by digit, then the result
// one output register; a new word is taken while a result waits
// a second result stalls in the sequencer until the output register frees
// async active-low reset clears delay lines, control and registers (ratio to 512)
`timescale 1ns / 1ps

module three_tone_goertzel_detector_unit #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned STATE_BITS  = 40
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]           s_axis_tdata,  // sample
  input  logic                                       s_axis_tlast,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // magnitude_a, magnitude_b, magnitude_c, dominant_found, dominant_bin
  output logic [ttgd_pkg::ResW-1:0]                  m_axis_tdata,
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [ttgd_pkg::AddrW-1:0]                 paddr,
  input  logic [31:0]                                pwdata,
  output logic [31:0]                                prdata,
  output logic                                       pready
);

  localparam int unsigned AW   = STATE_BITS + ttgd_pkg::CoefW;
  localparam int unsigned ACCW = 2 * STATE_BITS + ttgd_pkg::CoefW;

  ttgd_pkg::cfg_t            cfg;
  ttgd_pkg::mac_ctl_t        mac_ctl;
  logic signed [AW-1:0]      mac_a;
  logic [ttgd_pkg::MagW-1:0] mac_top;
  logic signed [ACCW-1:0]    mac_acc;
  logic                      res_valid;
  logic                      res_ready;
  ttgd_pkg::res_t            res;
  ttgd_pkg::res_t            out_q, out_d;
  logic                      out_valid_q, out_valid_d;

  assign pready = 1'b1;

  ttgd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  ttgd_mac #(
    .AW   (AW),
    .ACCW (ACCW)
  ) u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .a_i   (mac_a),
    .top_i (mac_top),
    .acc_o (mac_acc)
  );

  ttgd_seq #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .STATE_BITS  (STATE_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
    .in_last_i   (s_axis_tlast),
    .cfg_i       (cfg),
    .mac_ctl_o   (mac_ctl),
    .mac_a_o     (mac_a),
    .mac_top_o   (mac_top),
    .mac_acc_i   (mac_acc),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for three_tone_goertzel_detector_unit: sample blocks in,
// one energy/dominance report per block out, scored against an in-bench goertzel model or fixed values
// depends on ttgd_pkg and the unit's rtl
`timescale 1ns / 1ps

module testbench;
  import ttgd_pkg::*;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    reg_idx_e    idx;
    logic [15:0] val;
    logic        lst;
    logic        typed;
    res_t        want;
  } stim_row_t;

  localparam longint StHi = (64'sd1 <<< 39) - 1;
  localparam longint StLo = -StHi - 1;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata;  // sample
  logic              s_axis_tlast;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  // magnitude_a, magnitude_b, magnitude_c, dominant_found, dominant_bin
  logic [ResW-1:0]   m_axis_tdata;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // goertzel model state and register copies
  logic signed [39:0] tap1 [3];
  logic signed [39:0] tap2 [3];
  logic signed [15:0] coef_q [3];
  logic [15:0]        ratio_q;

  res_t expected_reports [$];
  res_t got_report;
  res_t want_report;
  bit   quiet;
  int   mismatches;
  int   words_sent;
  int   blocks_sent;
  int   reports_checked;
  int   reg_writes;

  three_tone_goertzel_detector_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // one goertzel step on all bins; a marked word also yields the energy report
  task automatic advance_bins(input logic signed [11:0] x, input logic mark,
                              output bit made, output res_t r);
    logic signed [63:0]  xs;
    logic signed [63:0]  prod;
    logic signed [63:0]  s0;
    logic signed [127:0] w1;
    logic signed [127:0] w2;
    logic signed [127:0] wc;
    logic signed [127:0] acc;
    logic [62:0]         mag [3];
    logic [62:0]         top;
    logic [62:0]         second;
    logic [127:0]        lhs;
    logic [127:0]        rhs;
    int                  best;
    bit                  found;
    xs = x;
    for (int i = 0; i < 3; i++) begin
      prod = coef_q[i] * tap1[i];
      s0 = xs + (prod >>> 14) - tap2[i];
      if (s0 > StHi) s0 = StHi;
      else if (s0 < StLo) s0 = StLo;
      tap2[i] = tap1[i];
      tap1[i] = s0[39:0];
    end
    made = mark;
    r = '0;
    if (!mark) return;
    for (int i = 0; i < 3; i++) begin
      w1 = tap1[i];
      w2 = tap2[i];
      wc = coef_q[i];
      acc = w1 * w1 + w2 * w2 - ((wc * w1 * w2) >>> 14);
      if (acc[127]) mag[i] = '0;
      else if (|acc[126:63]) mag[i] = MagMax;
      else mag[i] = acc[62:0];
      tap1[i] = '0;
      tap2[i] = '0;
    end
    best = 0;
    for (int i = 1; i < 3; i++) if (mag[i] > mag[best]) best = i;
    top = mag[best];
    second = '0;
    for (int i = 0; i < 3; i++) if (i != best && mag[i] > second) second = mag[i];
    if (top != 0 && second != 0) begin
      lhs = top;
      lhs = lhs << 8;
      rhs = second;
      rhs = rhs * ratio_q;
      found = (lhs >= rhs);
    end else begin
      found = (top != 0);
    end
    r.mag_a = mag[0];
    r.mag_b = mag[1];
    r.mag_c = mag[2];
    r.found = found;
    r.bin   = found ? 2'(best) : 2'd0;
  endtask

  task automatic send_word(input logic signed [11:0] x, input logic lst,
                           input bit typed, input res_t want);
    int   gap;
    bit   made;
    res_t r;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, x};
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    advance_bins(x, lst, made, r);
    if (made) expected_reports.push_back(typed ? want : r);
    words_sent++;
    if (lst) blocks_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (idx == REG_MIN_RATIO) ? {16'h0000, v} : {{16{v[15]}}, v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_MIN_RATIO) ratio_q = v;
    else coef_q[idx] = v;
    reg_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // block must be idle: all reports back, then room for a trailing unmarked word
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic flag_mismatch(input string what, input logic [62:0] want,
                               input logic [62:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic cmp_field(input string what, input logic [62:0] want,
                           input logic [62:0] got);
    if (want !== got) flag_mismatch(what, want, got);
  endtask

  function automatic stim_row_t word_row(input logic [11:0] x, input logic lst);
    stim_row_t row;
    row = '0;
    row.kind = ROW_WORD;
    row.val  = {4'b0000, x};
    row.lst  = lst;
    return row;
  endfunction

  function automatic stim_row_t checked_row(input logic [11:0] x, input logic [62:0] a,
                                            input logic [62:0] b, input logic [62:0] c,
                                            input logic found, input logic [1:0] bin);
    stim_row_t row;
    row = word_row(x, 1'b1);
    row.typed      = 1'b1;
    row.want.mag_a = a;
    row.want.mag_b = b;
    row.want.mag_c = c;
    row.want.found = found;
    row.want.bin   = bin;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input reg_idx_e idx, input logic [15:0] v);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.idx  = idx;
    row.val  = v;
    return row;
  endfunction

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'(32767 - $urandom_range(0, 2000));
      4:       return 16'(-32768 + $urandom_range(0, 2000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_ratio();
    case ($urandom_range(0, 3))
      0:       return 16'd256;
      1:       return 16'd65535;
      2:       return 16'($urandom_range(256, 1024));
      default: return 16'($urandom_range(256, 65535));
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_report = m_axis_tdata;
      reports_checked++;
      if (expected_reports.size() == 0) begin
        flag_mismatch("report with none pending", '0, got_report.mag_a);
      end else begin
        want_report = expected_reports.pop_front();
        cmp_field("magnitude_a", want_report.mag_a, got_report.mag_a);
        cmp_field("magnitude_b", want_report.mag_b, got_report.mag_b);
        cmp_field("magnitude_c", want_report.mag_c, got_report.mag_c);
        cmp_field("dominant_found", 63'(want_report.found), 63'(got_report.found));
        cmp_field("dominant_bin", 63'(want_report.bin), 63'(got_report.bin));
      end
    end
  end

  // report side backpressure
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk_i);
    end
  end

  initial begin
    stim_row_t         dir_rows [$];
    logic signed [11:0] x;
    logic [11:0]        base;
    logic [11:0]        pat [8];
    int                 sent;
    int                 len;
    int                 mode;
    int                 per;
    int                 k;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    quiet         = 1'b0;
    mismatches    = 0;
    words_sent    = 0;
    blocks_sent   = 0;
    reports_checked = 0;
    reg_writes    = 0;
    ratio_q       = RatioReset;
    for (int i = 0; i < 3; i++) begin
      tap1[i]   = '0;
      tap2[i]   = '0;
      coef_q[i] = '0;
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    dir_rows = '{
      // reset coefficients: every bin sees the bare sample, equal energies do not dominate at the reset ratio
      checked_row(12'h800, 63'd4194304, 63'd4194304, 63'd4194304, 1'b0, 2'd0),
      checked_row(12'h7FF, 63'd4190209, 63'd4190209, 63'd4190209, 1'b0, 2'd0),
      checked_row(12'h000, 63'd0, 63'd0, 63'd0, 1'b0, 2'd0),
      word_row(12'd5, 1'b0),
      checked_row(12'hFFD, 63'd34, 63'd34, 63'd34, 1'b0, 2'd0),
      reg_row(REG_COEF_A, 16'h7FFF),
      reg_row(REG_COEF_B, 16'h8000),
      reg_row(REG_COEF_C, 16'h0000),
      reg_row(REG_MIN_RATIO, 16'hFFFF),
      // dc run, then nyquist run
      word_row(12'h7FF, 1'b0), word_row(12'h7FF, 1'b0), word_row(12'h7FF, 1'b0),
      word_row(12'h7FF, 1'b0), word_row(12'h7FF, 1'b1),
      word_row(12'h7FF, 1'b0), word_row(12'h800, 1'b0), word_row(12'h7FF, 1'b0),
      word_row(12'h800, 1'b1),
      reg_row(REG_COEF_A, 16'h8000),
      reg_row(REG_MIN_RATIO, 16'd256),
      // two bins cancel to zero, third alone has energy
      word_row(12'd100, 1'b0),
      checked_row(12'd100, 63'd0, 63'd0, 63'd20000, 1'b1, 2'd2),
      word_row(12'h800, 1'b0),
      checked_row(12'h800, 63'd0, 63'd0, 63'd8388608, 1'b1, 2'd2),
      // tie between first two bins at the lowest ratio
      word_row(12'h7FF, 1'b0),
      word_row(12'h800, 1'b1)
    };

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        wait_drained();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_word(dir_rows[i].val[11:0], dir_rows[i].lst, dir_rows[i].typed,
                  dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      write_reg(REG_COEF_A, pick_coef());
      write_reg(REG_COEF_B, pick_coef());
      write_reg(REG_COEF_C, pick_coef());
      write_reg(REG_MIN_RATIO, pick_ratio());
      quiet = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < 260) begin
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
        mode = $urandom_range(0, 4);
        per  = $urandom_range(2, 8);
        case ($urandom_range(0, 2))
          0:       base = 12'h800;
          1:       base = 12'h7FF;
          default: base = 12'($urandom);
        endcase
        for (k = 0; k < 8; k++) pat[k] = 12'($urandom);
        for (k = 0; k < len; k++) begin
          case (mode)
            0:       x = 12'($urandom);
            1:       x = 12'($urandom_range(0, 15)) - 12'd8;
            2:       x = base;
            3:       x = k[0] ? ~base : base;
            default: x = pat[k % per];
          endcase
          send_word(x, k == len - 1, 1'b0, '0);
          sent++;
        end
      end
    end

    // long nyquist run with coefficients at -2 drives the state into saturation
    wait_drained();
    write_reg(REG_COEF_A, 16'h8000);
    write_reg(REG_COEF_B, 16'h8000);
    write_reg(REG_COEF_C, 16'h8000);
    write_reg(REG_MIN_RATIO, 16'd256);
    quiet = 1'b1;
    for (k = 0; k < 24000; k++) send_word(k[0] ? 12'h800 : 12'h7FF, 1'b0, 1'b0, '0);
    wait_drained();
    write_reg(REG_COEF_A, 16'h8001);
    write_reg(REG_COEF_B, 16'h0000);
    send_word(12'h7FF, 1'b1, 1'b0, '0);
    quiet = 1'b0;

    wait_drained();
    $display("sent %0d words in %0d blocks over %0d register writes", words_sent,
             blocks_sent, reg_writes);
    $display("checked %0d reports, %0d field mismatches", reports_checked, mismatches);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
